@@ rtl/fec_block_erasure_tracker_defines.svh @@
// assertion macros for the erasure tracker
// no dependencies
`ifndef FEC_BLOCK_ERASURE_TRACKER_DEFINES_SVH
`define FEC_BLOCK_ERASURE_TRACKER_DEFINES_SVH
// clocked assertion with asynchronous reset disable
`define FBET_ASSERT(label, clk_s, rst_n, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (prop)) else $error(msg);
// implication assertion
`define FBET_IMPLY(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

@@ rtl/fbet_pkg.sv @@
// package for the erasure tracker: payload types, constants, register and item kind codes
// no dependencies
package fbet_pkg;
	localparam int unsigned NUM_BUFFERS_DEF  = 1;
	localparam int unsigned MAX_PER_KIND_DEF = 32;
	localparam int unsigned SLOTS            = 64;
	localparam int unsigned RESTART_MARGIN   = 128;
	localparam logic [15:0] CNT_MAX          = 16'hFFFF;
	localparam logic [5:0]  DATA_COUNT_RST   = 6'd8;
	localparam logic [5:0]  FEC_COUNT_RST    = 6'd4;
	localparam logic        REG_DATA_COUNT   = 1'b0;
	localparam logic        REG_FEC_COUNT    = 1'b1;
	localparam logic        KIND_REPORT      = 1'b0;
	localparam logic        KIND_ACK         = 1'b1;

	typedef struct packed {
		logic [31:0] seq_num;
		logic        crc_ok;
	} in_item_t;

	typedef struct packed {
		logic        item_kind;
		logic [4:0]  slot_index;
		logic        publish;
		logic        repaired;
		logic [4:0]  fec_index;
		logic [31:0] retired_block;
		logic        block_failed;
		logic        stored;
		logic        restart_seen;
		logic [15:0] restart_total;
		logic [15:0] damaged_total;
		logic        last;
	} out_item_t;

	// divider control between top and divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

@@ rtl/fec_block_erasure_tracker.sv @@
// top level of the erasure tracker: sequencer, slot flags, retirement scan
// uses fbet_pkg, fbet_divider and fec_block_erasure_tracker_defines.svh
//
// usage: one packet item (sequence number, crc flag) enters on the in channel
// (in_valid / in_stall); results leave on the out channel (out_valid /
// out_stall). each packet gives d slot reports when it retires the buffered
// block, then one acknowledgement with last set.
// cfg_we / cfg_index / cfg_data write data_count (0) and fec_count (1); write
// only while idle.
// d is data_count (0 read as 1), f is fec_count, both capped at MAX_PER_KIND.
// the divider splits the sequence number by d + f into block and slot; the
// pick, store and ack steps follow. a retirement adds, after pick, a counting
// scan over max(d, f) slot pairs and a pairing scan that reports the d data
// slots and passes over skipped fec slots, at most one report a cycle while
// the output does not stall.
// one item at a time: in_stall stays high until the ack has been loaded.
// a stalled output holds its item; the scan waits with it.
// reset empties the window, clears slot flags and counters, and returns to idle.
module fec_block_erasure_tracker #(
	parameter int unsigned NUM_BUFFERS  = fbet_pkg::NUM_BUFFERS_DEF,
	parameter int unsigned MAX_PER_KIND = fbet_pkg::MAX_PER_KIND_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fbet_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output fbet_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [5:0]          cfg_data
);
	import fbet_pkg::*;
	`include "fec_block_erasure_tracker_defines.svh"

	localparam int unsigned BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam logic [33:0] MARGIN = 34'(RESTART_MARGIN * NUM_BUFFERS);
	localparam logic [5:0]  MPK = 6'(MAX_PER_KIND);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_PICK  = 7'b0000100,
		ST_COUNT = 7'b0001000,
		ST_PAIR  = 7'b0010000,
		ST_STORE = 7'b0100000,
		ST_ACK   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [5:0] data_count_q, fec_count_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_count_q <= DATA_COUNT_RST;
			fec_count_q  <= FEC_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DATA_COUNT: data_count_q <= cfg_data;
				REG_FEC_COUNT:  fec_count_q  <= cfg_data;
				default:        ;
			endcase
		end
	end

	// effective counts latched per packet
	logic [5:0] d_eff, f_eff;
	assign d_eff = (data_count_q == 6'd0) ? 6'd1 :
		((data_count_q > MPK) ? MPK : data_count_q);
	assign f_eff = (fec_count_q > MPK) ? MPK : fec_count_q;
	logic [5:0] d_q, f_q;

	// window state
	logic [31:0] buf_block_q [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] buf_used_q;
	logic [SLOTS-1:0] valid_q [NUM_BUFFERS];
	logic [SLOTS-1:0] good_q  [NUM_BUFFERS];
	logic [31:0] highest_q;
	logic        started_q;
	logic [15:0] restart_cnt_q, damaged_cnt_q;

	// per-packet registers
	logic        crc_q;
	logic [31:0] blk_q;
	logic [5:0]  slot_q;
	logic        restart_q, stored_q;
	logic [BW-1:0] victim_q;

	// divider
	div_ctl_t    dctl;
	logic [31:0] quo;
	logic [6:0]  rem;
	logic        div_start;
	fbet_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(in_item.seq_num),
		.divisor({1'b0, d_eff} + {1'b0, f_eff}),
		.ctl(dctl), .quotient(quo), .remainder(rem)
	);

	logic accept_in;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign div_start = accept_in;

	// shared slot-pair unit: position of data k and fec k
	logic [5:0] di_q, fi_q;
	logic [5:0] dpos, fpos;
	logic       dv, dg, fv, fg;
	logic [SLOTS-1:0] vsel, gsel;
	assign vsel = valid_q[victim_q];
	assign gsel = good_q[victim_q];
	assign dpos = (di_q < f_q) ? {di_q[4:0], 1'b0} : (di_q + f_q);
	assign fpos = (fi_q < d_q) ? {fi_q[4:0], 1'b1} : (fi_q + d_q);
	assign dv = vsel[dpos];
	assign dg = gsel[dpos];
	assign fv = vsel[fpos];
	assign fg = gsel[fpos];

	// counting results
	logic [6:0] dm_q, dc_q, good_q7;
	logic       failed_q;

	// victim selection
	logic [BW-1:0] vict;
	always_comb begin
		vict = '0;
		for (int b = 1; b < NUM_BUFFERS; b++) begin
			if (!buf_used_q[b]) begin
				if (buf_used_q[vict]) vict = BW'(b);
			end else if (buf_used_q[vict] && buf_block_q[b] < buf_block_q[vict]) begin
				vict = BW'(b);
			end
		end
	end

	// newer block, restart jump and whether the window takes the block
	logic pick_newer, pick_rst, pick_open;
	assign pick_newer = !started_q || blk_q > highest_q;
	assign pick_rst   = started_q && (({2'b0, blk_q} + MARGIN) < {2'b0, highest_q});
	assign pick_open  = (pick_newer || pick_rst) && crc_q;

	// pairing decision for the current pair
	logic di_live, fi_live, skip_d, skip_f;
	assign di_live = di_q < d_q;
	assign fi_live = fi_q < f_q;
	assign skip_d  = (dv && dg) || (dv && !dg && good_q7 <= dm_q);
	assign skip_f  = !fv || (!fg && dm_q > good_q7);

	logic pair_skip_f, pair_rep;
	assign pair_skip_f = fi_live && di_live && !skip_d && skip_f;
	assign pair_rep    = fi_live && !skip_d;

	// end of the counting scan and the totals including the current pair
	logic       count_last;
	logic [6:0] bad_total, good_total;
	assign count_last = !(di_q + 6'd1 < d_q) && !(fi_q + 6'd1 < f_q);
	assign bad_total  = dm_q + dc_q + {6'd0, di_live && !(dv && dg)};
	assign good_total = good_q7 + {6'd0, fi_live && fv && fg};

	// output register
	out_item_t oreg_q;
	logic      ovalid_q;
	logic      out_free;
	logic      out_load;
	assign out_free  = !ovalid_q || !out_stall;
	assign out_load  = out_free &&
		(((state_q == ST_PAIR) && !pair_skip_f) || (state_q == ST_ACK));
	assign out_valid = ovalid_q;
	assign out_item  = oreg_q;

	// report and acknowledgement items
	out_item_t rep_item, ack_item;
	always_comb begin
		rep_item               = '0;
		rep_item.item_kind     = KIND_REPORT;
		rep_item.slot_index    = di_q[4:0];
		rep_item.publish       = !failed_q || dv;
		rep_item.repaired      = pair_rep;
		rep_item.fec_index     = pair_rep ? fi_q[4:0] : 5'd0;
		rep_item.retired_block = buf_block_q[victim_q];
		rep_item.block_failed  = failed_q;
		rep_item.restart_total = restart_cnt_q;
		rep_item.damaged_total = damaged_cnt_q;
		ack_item               = '0;
		ack_item.item_kind     = KIND_ACK;
		ack_item.stored        = stored_q;
		ack_item.restart_seen  = restart_q;
		ack_item.restart_total = restart_cnt_q;
		ack_item.damaged_total = damaged_cnt_q;
		ack_item.last          = 1'b1;
	end

	// lookup of held buffer for store
	logic          hit;
	logic [BW-1:0] hit_b;
	always_comb begin
		hit = 1'b0;
		hit_b = '0;
		for (int b = NUM_BUFFERS - 1; b >= 0; b--) begin
			if (buf_used_q[b] && buf_block_q[b] == blk_q) begin
				hit = 1'b1;
				hit_b = BW'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			buf_used_q    <= '0;
			highest_q     <= '0;
			started_q     <= 1'b0;
			restart_cnt_q <= '0;
			damaged_cnt_q <= '0;
			ovalid_q      <= 1'b0;
			for (int b = 0; b < NUM_BUFFERS; b++) begin
				valid_q[b] <= '0;
				good_q[b]  <= '0;
			end
		end else begin
			ovalid_q <= out_load || (ovalid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						crc_q   <= in_item.crc_ok;
						d_q     <= d_eff;
						f_q     <= f_eff;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dctl.done) begin
						blk_q   <= quo;
						slot_q  <= rem[5:0];
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					restart_q <= pick_rst && crc_q;
					stored_q  <= 1'b0;
					victim_q  <= (pick_open && pick_rst) ? BW'(0) : vict;
					di_q <= '0;
					fi_q <= '0;
					dm_q <= '0;
					dc_q <= '0;
					good_q7 <= '0;
					state_q <= ST_STORE;
					if (pick_open) begin
						if (pick_rst) begin
							if (restart_cnt_q != CNT_MAX) restart_cnt_q <= restart_cnt_q + 16'd1;
							// restart empties the window, then buffer 0 takes the block
							buf_used_q <= NUM_BUFFERS'(1);
							for (int b = 0; b < NUM_BUFFERS; b++) begin
								valid_q[b] <= '0;
								good_q[b]  <= '0;
							end
							buf_block_q[0] <= blk_q;
						end else if (buf_used_q[vict]) begin
							state_q <= ST_COUNT;
						end else begin
							buf_block_q[vict] <= blk_q;
							buf_used_q[vict]  <= 1'b1;
						end
						highest_q <= blk_q;
						started_q <= 1'b1;
					end
				end
				ST_COUNT: begin
					// one data slot and one fec slot tallied per cycle
					if (di_live) begin
						if (!dv) dm_q <= dm_q + 7'd1;
						else if (!dg) dc_q <= dc_q + 7'd1;
					end
					if (fi_live && fv && fg) good_q7 <= good_q7 + 7'd1;
					di_q <= count_last ? 6'd0 : di_q + 6'd1;
					fi_q <= count_last ? 6'd0 : fi_q + 6'd1;
					if (count_last) begin
						failed_q <= bad_total > good_total;
						if (bad_total > good_total && damaged_cnt_q != CNT_MAX)
							damaged_cnt_q <= damaged_cnt_q + 16'd1;
						state_q <= ST_PAIR;
					end
				end
				ST_PAIR: begin
					// each cycle either skips a fec slot or, while the output is free, reports one data slot
					if (pair_skip_f) begin
						fi_q <= fi_q + 6'd1;
					end else if (out_free) begin
						oreg_q <= rep_item;
						if (pair_rep) begin
							if (!dv) dm_q <= dm_q - 7'd1;
							else dc_q <= dc_q - 7'd1;
							if (fg) good_q7 <= good_q7 - 7'd1;
							fi_q <= fi_q + 6'd1;
						end
						di_q <= di_q + 6'd1;
						if (!(di_q + 6'd1 < d_q)) begin
							valid_q[victim_q]     <= '0;
							good_q[victim_q]      <= '0;
							buf_block_q[victim_q] <= blk_q;
							state_q <= ST_STORE;
						end
					end
				end
				ST_STORE: begin
					if (hit && !good_q[hit_b][slot_q]) begin
						valid_q[hit_b][slot_q] <= 1'b1;
						good_q[hit_b][slot_q]  <= crc_q;
						stored_q <= 1'b1;
					end
					state_q <= ST_ACK;
				end
				ST_ACK: begin
					if (out_free) begin
						oreg_q  <= ack_item;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FBET_ASSERT(a_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`FBET_IMPLY(a_stall_busy, clk, arst_n, state_q != ST_IDLE, in_stall, "ready while busy")
	`FBET_IMPLY(a_hold, clk, arst_n, ovalid_q && out_stall, ##1 (ovalid_q && $stable(oreg_q)),
		"stalled item changed")
	`FBET_IMPLY(a_ack_last, clk, arst_n, ovalid_q, oreg_q.last == oreg_q.item_kind,
		"last not on ack")
endmodule

@@ rtl/fbet_divider.sv @@
// restoring radix-2 divider: 32-bit dividend by 7-bit divisor, one bit a cycle
// uses fbet_pkg
module fbet_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          dividend,
	input  logic [6:0]           divisor,
	output fbet_pkg::div_ctl_t   ctl,
	output logic [31:0]          quotient,
	output logic [6:0]           remainder
);
	import fbet_pkg::*;

	logic [31:0] q_q;
	logic [6:0]  r_q;
	logic [6:0]  d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [7:0]  trial;

	assign trial = {r_q, q_q[31]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[7]) begin
				r_q <= trial[6:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= {r_q[5:0], q_q[31]};
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign ctl.start  = start;
	assign ctl.busy   = busy_q;
	assign ctl.done   = done_q;
	assign quotient   = q_q;
	assign remainder  = r_q;
endmodule
